FILE: hw/rtl/sha1_message_hasher_defines.svh
// Assertion macros used by the checker file of the hasher.
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH

// Check a property outside of reset.
`define SHA1MH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SHA1MH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/sha1mh_pkg.sv
package sha1mh_pkg;

  // Channel widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = 5;
  localparam int WIDX_W      = 3;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Hash constants
  localparam int            DIGEST_WORDS = 5;
  localparam logic [6:0]    LAST_ROUND   = 7'd79;
  localparam logic [7:0]    PAD_MARK     = 8'h80;
  localparam logic [WIDX_W-1:0] LAST_WIDX = 3'd4;
  localparam logic [31:0]   H_INIT [DIGEST_WORDS] =
    '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0]   K_0 = 32'h5A827999;
  localparam logic [31:0]   K_1 = 32'h6ED9EBA1;
  localparam logic [31:0]   K_2 = 32'h8F1BBCDC;
  localparam logic [31:0]   K_3 = 32'hCA62C1D6;

  // Fill positions that steer padding
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] FILL_PRE_LEN = 6'd55;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0]       word;
    logic [WIDX_W-1:0] idx;
    logic              last;
    logic              failed;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  // Round function plus round constant, by round range
  function automatic logic [31:0] round_fk(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd) inside
      [7'd0:7'd19]:  f = ((b & c) | (~b & d)) + K_0;
      [7'd20:7'd39]: f = (b ^ c ^ d) + K_1;
      [7'd40:7'd59]: f = ((b & c) | (b & d) | (c & d)) + K_2;
      default:       f = (b ^ c ^ d) + K_3;
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/sha1mh_front.sv
module sha1mh_front
  import sha1mh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  full
);

  logic stage_vld_r, stage_vld_nxt;
  cmd_t stage_cmd_r;
  logic accept;

  // Take a beat whenever the stage is free or drains this cycle
  assign push      = stage_vld_r && !full;
  assign in_tready = !stage_vld_r || !full;
  assign accept    = in_tvalid && in_tready;
  assign push_cmd  = stage_cmd_r;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (accept) begin
      stage_vld_nxt = 1'b1;
    end else if (push) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  // Classify: tuser marks a finish, tdata carries the byte
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd_r.fin  <= in_tuser;
      stage_cmd_r.data <= in_tdata;
    end
  end

endmodule

FILE: hw/rtl/sha1mh_fifo.sv
module sha1mh_fifo
  import sha1mh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/sha1mh_back.sv
module sha1mh_back
  import sha1mh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  state_t            state_r, state_nxt;
  logic [31:0]       h_r [DIGEST_WORDS];
  logic [31:0]       h_nxt [DIGEST_WORDS];
  logic [31:0]       w_r [16];
  logic [31:0]       w_nxt [16];
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [60:0]       cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [6:0]        rnd_r, rnd_nxt;
  logic              mark_r, mark_nxt;
  logic              len_r, len_nxt;
  logic              padret_r, padret_nxt;
  logic              final_r, final_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_res_r, out_res_nxt;

  logic              push_en;
  logic [7:0]        push_byte;
  logic [61:0]       cnt_inc;
  logic [63:0]       bitlen;
  logic [7:0]        len_byte;
  logic [31:0]       t_sum;

  assign cnt_inc   = {1'b0, cnt_r} + 62'd1;
  assign bitlen    = {cnt_r, 3'b000};
  assign len_byte  = bitlen[{~fill_r[2:0], 3'b000} +: 8];
  assign t_sum     = rotl5(a_r) + round_fk(rnd_r, b_r, c_r, d_r) + e_r + w_r[0];
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt   = state_r;
    h_nxt       = h_r;
    w_nxt       = w_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    e_nxt       = e_r;
    acc_nxt     = acc_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    rnd_nxt     = rnd_r;
    mark_nxt    = mark_r;
    len_nxt     = len_r;
    padret_nxt  = padret_r;
    final_nxt   = final_r;
    widx_nxt    = widx_r;
    out_res_nxt = out_res_r;
    out_vld_nxt = out_vld_r && !out_ready;
    q_pop       = 1'b0;
    push_en     = 1'b0;
    push_byte   = '0;

    case (state_r)
      // Take one command: absorb a byte (dropped once the length overflowed) or start the finish
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.fin) begin
            mark_nxt  = 1'b0;
            len_nxt   = 1'b0;
            final_nxt = 1'b0;
            widx_nxt  = '0;
            state_nxt = ovf_r ? ST_EMIT : ST_PAD;
          end else if (!ovf_r) begin
            push_en   = 1'b1;
            push_byte = q_cmd.data;
            cnt_nxt   = cnt_inc[60:0];
            if (cnt_inc[61]) begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end

      // Feed the marker, zero fill and the length, one byte a cycle
      ST_PAD: begin
        push_en = 1'b1;
        if (!mark_r) begin
          push_byte = PAD_MARK;
          mark_nxt  = 1'b1;
          if (fill_r == FILL_PRE_LEN) begin
            len_nxt = 1'b1;
          end
        end else if (len_r) begin
          push_byte = len_byte;
          if (fill_r == FILL_LAST) begin
            final_nxt = 1'b1;
          end
        end else begin
          push_byte = '0;
          if (fill_r == FILL_PRE_LEN) begin
            len_nxt = 1'b1;
          end
        end
      end

      // One round per cycle, schedule window slides along
      ST_COMP: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = rotl30(b_r);
        b_nxt = a_r;
        a_nxt = t_sum;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = rotl1(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end

      // Add the working words into the chaining value
      ST_FOLD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (padret_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // Load one digest word per free output slot (a single failed beat on overflow), then restart
      ST_EMIT: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt = 1'b1;
          if (ovf_r) begin
            out_res_nxt.word   = '0;
            out_res_nxt.idx    = '0;
            out_res_nxt.last   = 1'b1;
            out_res_nxt.failed = 1'b1;
          end else begin
            out_res_nxt.word   = h_r[widx_r];
            out_res_nxt.idx    = widx_r;
            out_res_nxt.last   = widx_r == LAST_WIDX;
            out_res_nxt.failed = 1'b0;
            widx_nxt           = widx_r + 1'b1;
          end
          if (ovf_r || widx_r == LAST_WIDX) begin
            h_nxt      = H_INIT;
            fill_nxt   = '0;
            cnt_nxt    = '0;
            ovf_nxt    = 1'b0;
            mark_nxt   = 1'b0;
            len_nxt    = 1'b0;
            final_nxt  = 1'b0;
            padret_nxt = 1'b0;
            widx_nxt   = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Pack bytes into big-endian words and shift them into the window
    if (push_en) begin
      fill_nxt = fill_r + 1'b1;
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = {acc_r, push_byte};
      end else begin
        acc_nxt = {acc_r[15:0], push_byte};
      end
      if (fill_r == FILL_LAST) begin
        a_nxt      = h_r[0];
        b_nxt      = h_r[1];
        c_nxt      = h_r[2];
        d_nxt      = h_r[3];
        e_nxt      = h_r[4];
        rnd_nxt    = '0;
        padret_nxt = state_r == ST_PAD;
        state_nxt  = ST_COMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      h_r       <= H_INIT;
      fill_r    <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      rnd_r     <= '0;
      mark_r    <= 1'b0;
      len_r     <= 1'b0;
      padret_r  <= 1'b0;
      final_r   <= 1'b0;
      widx_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      h_r       <= h_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      rnd_r     <= rnd_nxt;
      mark_r    <= mark_nxt;
      len_r     <= len_nxt;
      padret_r  <= padret_nxt;
      final_r   <= final_nxt;
      widx_r    <= widx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    d_r       <= d_nxt;
    e_r       <= e_nxt;
    acc_r     <= acc_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

FILE: hw/rtl/sha1_message_hasher.sv
// Channel | Dir | tdata (low bit up)                   | tuser      | tlast
// in_     | in  | data_byte[7:0]                       | op         | -
// out_    | out | digest_word[31:0], word_index[34:32] | failed     | last_word
//
// The back engine absorbs each byte from the queue; a full 64-byte block then
// adds 80 rounds of one shared round unit plus the fold. A finish feeds 9 to 72
// pad bytes at one per cycle between its one or two compressions, then five
// beats (one on length overflow).
// Reset is synchronous and needs no clearing pass. A four-beat command queue
// lets input keep arriving while the engine compresses or the output stalls.
module sha1_message_hasher
  import sha1mh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic                   out_tuser,  // [0] failed
  output logic                   out_tlast
);

  logic push, full, pop, not_empty;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  sha1mh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  sha1mh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  sha1mh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result beat
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.idx, res.word};
  assign out_tuser = res.failed;
  assign out_tlast = res.last;

endmodule

FILE: hw/rtl/sha1mh_checker.sv
`include "sha1_message_hasher_defines.svh"

module sha1mh_checker
  import sha1mh_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // Hold a stalled result beat
  `SHA1MH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")

  // Word index stays within the digest
  `SHA1MH_ASSERT(a_idx_range, out_tvalid |-> (out_tdata[34:32] == 3'd0) || (out_tdata[34:32] == 3'd1) || (out_tdata[34:32] == 3'd2) || (out_tdata[34:32] == 3'd3) || (out_tdata[34:32] == 3'd4), "word index out of range")

  // A failed beat is a lone, zeroed, final beat
  `SHA1MH_ASSERT(a_fail_beat, out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0), "malformed failed beat")

  // On a good digest, last marks exactly the fifth word
  `SHA1MH_ASSERT(a_last_word, out_tvalid && !out_tuser |-> (out_tlast == (out_tdata[34:32] == 3'd4)), "last flag on wrong word")

  // Reset drops the result channel
  `SHA1MH_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sha1_message_hasher sha1mh_checker u_chk (.*);
